// ===== sv/dqhist_pkg.sv =====
// Shared definitions for the readout parser and histogram unit.
// Holds request opcodes, readout marker words, data word field positions and widths, and the result record.
// No dependencies.
package dqhist_pkg;

  // Request opcodes.
  localparam logic [1:0] OP_WORD      = 2'd0;
  localparam logic [1:0] OP_READ_BIN  = 2'd1;
  localparam logic [1:0] OP_WRITE_MAP = 2'd2;

  // Readout stream markers.
  localparam logic [31:0] MARK_RUN_HEAD = 32'h9000_0000;
  localparam logic [31:0] MARK_HEAD_END = 32'h9fff_f000;
  localparam logic [31:0] MARK_EV_BEGIN = 32'h8000_0000;
  localparam logic [31:0] MARK_EV_END   = 32'h8fff_f000;
  localparam logic [31:0] MARK_FOOTER   = 32'ha000_0000;
  localparam logic [31:0] MARK_FILE_END = 32'hafff_f000;

  // Data word layout: channel in bits 22..12, sample in bits 11..0.
  localparam int          CH_LSB       = 12;
  localparam int          CH_W         = 11;
  localparam int          SAMPLE_W     = 12;
  localparam logic [11:0] SAMPLE_SKIP  = 12'd1023;

  // Field counts that follow the run header and the footer.
  localparam logic [2:0]  RUN_FIELDS    = 3'd4;
  localparam logic [2:0]  FOOTER_FIELDS = 3'd3;

  // Width of the reported bin value.
  localparam int          OUT_W = 32;

  typedef struct packed {
    logic [31:0] event_number;
    logic [31:0] run_number;
    logic [3:0]  phase;
    logic        finished;
  } status_t;

  typedef struct packed {
    logic [OUT_W-1:0] bin_value;
    status_t          status;
  } result_t;

endpackage

// ===== sv/daq_event_parser_histogram_unit.sv =====
// Readout stream parser with per-crate channel histograms.
// Requests pass stages 1 and 2 into the result queue; one per cycle while in_ready is high.
// The histogram update is a read-modify-write over a registered-read memory, with forwarding.
// Reset: synchronous, active low. After reset a clearing pass over all NUM_CRATES*NUM_CHANNELS
// histogram entries (384 by default) zeroes the histogram and channel map memories; no request is taken meanwhile.
// Depends on dqhist_pkg.
module daq_event_parser_histogram_unit
  import dqhist_pkg::*;
#(
  parameter int NUM_CHANNELS = 96,
  parameter int NUM_CRATES   = 4,
  parameter int BIN_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_word,
  input  logic [1:0]  in_crate_select,
  input  logic [6:0]  in_bin_index,
  input  logic [6:0]  in_map_channel,
  input  logic [6:0]  in_map_target,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_bin_value,
  output logic [31:0] out_event_number,
  output logic [31:0] out_run_number,
  output logic [3:0]  out_parse_phase,
  output logic        out_finished
);

  // Derived sizes. The histogram memory is laid out crate by crate, NUM_CHANNELS bins each.
  localparam int MAP_AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CRATE_W    = (NUM_CRATES > 1) ? $clog2(NUM_CRATES) : 1;
  localparam int HIST_DEPTH = NUM_CRATES * NUM_CHANNELS;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  // The result queue holds everything in flight, so the two pipeline stages never stall.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int CNT_W      = 3;

  // Parser phases, reported on out_parse_phase.
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RUN_HDR  = 4'd1,
    PH_EV_NUM   = 4'd2,
    PH_EV_TIME  = 4'd3,
    PH_CRAM_ID  = 4'd4,
    PH_FIFO_ID  = 4'd5,
    PH_WORD_CNT = 4'd6,
    PH_DATA     = 4'd7,
    PH_FOOTER   = 4'd8,
    PH_DONE     = 4'd9
  } phase_t;

  // ------------------------------------------------------------------------------------------
  // Parser state. The parser itself runs entirely at acceptance, so back-to-back readout words
  // see each other's effect without delay. Only the histogram work is pipelined behind it.
  // ------------------------------------------------------------------------------------------
  phase_t                phase_r, phase_nxt;
  logic [2:0]            fcnt_r, fcnt_nxt;
  logic [CRATE_W-1:0]    crate_r, crate_nxt;
  logic [31:0]           wleft_r, wleft_nxt;
  logic [31:0]           event_r, event_nxt;
  logic [31:0]           run_r, run_nxt;
  logic                  done_r, done_nxt;

  logic                  accept;
  logic                  word_go;
  logic                  dat_go;
  logic [2:0]            fcnt_dec;
  logic [31:0]           wleft_dec;
  logic                  last_crate;

  assign accept    = in_valid && in_ready;
  assign word_go   = accept && (in_op == OP_WORD) && !done_r;
  assign fcnt_dec  = (fcnt_r != 3'd0) ? fcnt_r - 3'd1 : fcnt_r;
  assign wleft_dec = wleft_r - 32'd1;
  assign last_crate = ({1'b0, crate_r} + (CRATE_W+1)'(1)) >= (CRATE_W+1)'(NUM_CRATES);

  always_comb begin
    phase_nxt = phase_r;
    fcnt_nxt  = fcnt_r;
    crate_nxt = crate_r;
    wleft_nxt = wleft_r;
    event_nxt = event_r;
    run_nxt   = run_r;
    done_nxt  = done_r;
    dat_go    = 1'b0;
    if (word_go) begin
      case (phase_r)
        PH_IDLE: begin
          // Header end, event end and unknown words leave the parser idle.
          if (in_word == MARK_RUN_HEAD) begin
            phase_nxt = PH_RUN_HDR;
            fcnt_nxt  = RUN_FIELDS;
          end else if (in_word == MARK_EV_BEGIN) begin
            phase_nxt = PH_EV_NUM;
          end else if (in_word == MARK_FOOTER) begin
            phase_nxt = PH_FOOTER;
            fcnt_nxt  = FOOTER_FIELDS;
          end else if (in_word == MARK_FILE_END) begin
            phase_nxt = PH_DONE;
            done_nxt  = 1'b1;
          end
        end
        PH_RUN_HDR: begin
          // The first field after the run header is the run number.
          if (fcnt_r == RUN_FIELDS) begin
            run_nxt = in_word;
          end
          fcnt_nxt = fcnt_dec;
          if (fcnt_dec == 3'd0) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_EV_NUM: begin
          event_nxt = in_word;
          phase_nxt = PH_EV_TIME;
        end
        PH_EV_TIME: begin
          crate_nxt = '0;
          phase_nxt = PH_CRAM_ID;
        end
        PH_CRAM_ID: begin
          phase_nxt = PH_FIFO_ID;
        end
        PH_FIFO_ID: begin
          phase_nxt = PH_WORD_CNT;
        end
        PH_WORD_CNT: begin
          wleft_nxt = in_word;
          if (in_word == 32'd0) begin
            // An empty section closes at once.
            if (last_crate) begin
              crate_nxt = '0;
              phase_nxt = PH_IDLE;
            end else begin
              crate_nxt = crate_r + CRATE_W'(1);
              phase_nxt = PH_CRAM_ID;
            end
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          // The datum is binned against the crate that is current before the section closes.
          dat_go    = 1'b1;
          wleft_nxt = wleft_dec;
          if (wleft_dec == 32'd0) begin
            if (last_crate) begin
              crate_nxt = '0;
              phase_nxt = PH_IDLE;
            end else begin
              crate_nxt = crate_r + CRATE_W'(1);
              phase_nxt = PH_CRAM_ID;
            end
          end
        end
        PH_FOOTER: begin
          fcnt_nxt = fcnt_dec;
          if (fcnt_dec == 3'd0) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      fcnt_r  <= 3'd0;
      crate_r <= '0;
      wleft_r <= 32'd0;
      event_r <= 32'd0;
      run_r   <= 32'd0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      fcnt_r  <= fcnt_nxt;
      crate_r <= crate_nxt;
      wleft_r <= wleft_nxt;
      event_r <= event_nxt;
      run_r   <= run_nxt;
      done_r  <= done_nxt;
    end
  end

  // ------------------------------------------------------------------------------------------
  // Stage 0 (acceptance): split the data word, start the channel map read, write the map for
  // a map request, and form the bin address for a bin read request.
  // ------------------------------------------------------------------------------------------
  logic [CH_W-1:0]     s0_ch;
  logic [SAMPLE_W-1:0] s0_sample;
  logic                s0_ch_ok;
  logic                s0_rd_ok;
  logic [HIST_AW-1:0]  s0_rd_addr;
  logic [CH_W-1:0]     s0_mc_ext;
  logic                s0_map_wr;
  status_t             s0_stat;

  assign s0_ch     = in_word[CH_LSB +: CH_W];
  assign s0_sample = (in_word[SAMPLE_W-1:0] == SAMPLE_SKIP) ? '0 : in_word[SAMPLE_W-1:0];
  assign s0_ch_ok  = {1'b0, s0_ch} < (CH_W+1)'(NUM_CHANNELS);
  assign s0_rd_ok  = ({3'b000, in_crate_select} < 5'(NUM_CRATES)) &&
                     ({5'b0, in_bin_index} < (CH_W+1)'(NUM_CHANNELS));
  assign s0_rd_addr = HIST_AW'(in_crate_select) * HIST_AW'(NUM_CHANNELS) +
                      HIST_AW'(in_bin_index);
  assign s0_mc_ext = {4'b0, in_map_channel};
  assign s0_map_wr = accept && (in_op == OP_WRITE_MAP) &&
                     ({1'b0, s0_mc_ext} < (CH_W+1)'(NUM_CHANNELS));

  // The result reports the state as it stands after this request.
  assign s0_stat.event_number = event_nxt;
  assign s0_stat.run_number   = run_nxt;
  assign s0_stat.phase        = phase_nxt;
  assign s0_stat.finished     = done_nxt;

  // ------------------------------------------------------------------------------------------
  // Clearing pass after reset: one histogram entry (and one map entry while in range) a cycle.
  // ------------------------------------------------------------------------------------------
  logic               clr_busy_r;
  logic [HIST_AW-1:0] clr_cnt_r;
  logic               clr_map;

  assign clr_map = clr_busy_r && ({1'b0, clr_cnt_r} < (HIST_AW+1)'(NUM_CHANNELS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + HIST_AW'(1);
      if (clr_cnt_r == HIST_AW'(HIST_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------------------------
  // Channel map memory. A map write and a later datum read are always in different cycles,
  // so no forwarding is needed here.
  // ------------------------------------------------------------------------------------------
  logic [6:0]        map_mem [NUM_CHANNELS];
  logic [6:0]        map_q;
  logic              map_we;
  logic [MAP_AW-1:0] map_wa;
  logic [6:0]        map_wd;
  logic [MAP_AW-1:0] map_ra;

  assign map_we = clr_map || s0_map_wr;
  assign map_wa = clr_busy_r ? clr_cnt_r[MAP_AW-1:0] : s0_mc_ext[MAP_AW-1:0];
  assign map_wd = clr_busy_r ? 7'd0 : in_map_target;
  assign map_ra = s0_ch[MAP_AW-1:0];

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_q <= map_mem[map_ra];
  end

  // ------------------------------------------------------------------------------------------
  // Stage 1: the mapped channel is back; form the bin address and start the histogram read.
  // ------------------------------------------------------------------------------------------
  logic                s1_v_r;
  logic                s1_dat_r;
  logic                s1_rd_r;
  logic                s1_ch_ok_r;
  logic [CRATE_W-1:0]  s1_crate_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [HIST_AW-1:0]  s1_rd_addr_r;
  status_t             s1_stat_r;

  logic [6:0]          s1_target;
  logic                s1_tgt_ok;
  logic [HIST_AW-1:0]  s1_dat_addr;
  logic [HIST_AW-1:0]  hist_ra;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
    s1_dat_r     <= dat_go;
    s1_rd_r      <= accept && (in_op == OP_READ_BIN) && s0_rd_ok;
    s1_ch_ok_r   <= s0_ch_ok;
    s1_crate_r   <= crate_r;
    s1_sample_r  <= s0_sample;
    s1_rd_addr_r <= s0_rd_addr;
    s1_stat_r    <= s0_stat;
  end

  // Raw channels past the map fall into bin 0; map entries past the bins drop the datum.
  assign s1_target   = s1_ch_ok_r ? map_q : 7'd0;
  assign s1_tgt_ok   = {5'b0, s1_target} < (CH_W+1)'(NUM_CHANNELS);
  assign s1_dat_addr = HIST_AW'(s1_crate_r) * HIST_AW'(NUM_CHANNELS) + HIST_AW'(s1_target);
  assign hist_ra     = s1_dat_r ? s1_dat_addr : s1_rd_addr_r;

  // ------------------------------------------------------------------------------------------
  // Histogram memory. The entry written at the same edge as a read returns stale data, so the
  // last write is held in wb_* and forwarded into stage 2 on an address match.
  // ------------------------------------------------------------------------------------------
  logic [BIN_BITS-1:0] hist_mem [HIST_DEPTH];
  logic [BIN_BITS-1:0] hist_q;
  logic                hist_we;
  logic [HIST_AW-1:0]  hist_wa;
  logic [BIN_BITS-1:0] hist_wd;

  logic                s2_v_r;
  logic                s2_dat_r;
  logic                s2_rd_r;
  logic [HIST_AW-1:0]  s2_addr_r;
  logic [SAMPLE_W-1:0] s2_sample_r;
  status_t             s2_stat_r;

  logic                wb_v_r;
  logic [HIST_AW-1:0]  wb_addr_r;
  logic [BIN_BITS-1:0] wb_data_r;

  logic [BIN_BITS-1:0] s2_old;
  logic [BIN_BITS:0]   s2_sum;
  logic [BIN_BITS-1:0] s2_new;
  logic                s2_wr;
  logic [OUT_W-1:0]    s2_rd_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_dat_r    <= s1_dat_r && s1_tgt_ok;
    s2_rd_r     <= s1_rd_r;
    s2_addr_r   <= hist_ra;
    s2_sample_r <= s1_sample_r;
    s2_stat_r   <= s1_stat_r;
  end

  // Stage 2: add with saturation and write back.
  assign s2_old = (wb_v_r && (wb_addr_r == s2_addr_r)) ? wb_data_r : hist_q;
  assign s2_sum = {1'b0, s2_old} + (BIN_BITS+1)'(s2_sample_r);
  assign s2_new = s2_sum[BIN_BITS] ? '1 : s2_sum[BIN_BITS-1:0];
  assign s2_wr  = s2_v_r && s2_dat_r;

  assign hist_we = clr_busy_r || s2_wr;
  assign hist_wa = clr_busy_r ? clr_cnt_r : s2_addr_r;
  assign hist_wd = clr_busy_r ? '0 : s2_new;

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_q <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_v_r <= 1'b0;
    end else begin
      wb_v_r <= s2_wr;
    end
    wb_addr_r <= s2_addr_r;
    wb_data_r <= s2_new;
  end

  // A bin wider than the reported value reads as all ones once it passes that range.
  if (BIN_BITS > OUT_W) begin : g_wide_bin
    assign s2_rd_val = (|s2_old[BIN_BITS-1:OUT_W]) ? '1 : s2_old[OUT_W-1:0];
  end else begin : g_narrow_bin
    assign s2_rd_val = OUT_W'(s2_old);
  end

  // ------------------------------------------------------------------------------------------
  // Result queue. Input ready counts the requests still in the pipeline as well as the queued
  // results, so a result always finds room and the memories never have to hold a request.
  // ------------------------------------------------------------------------------------------
  result_t             fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_r;
  logic [FIFO_AW-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]    fifo_cnt_r;
  logic [CNT_W-1:0]    in_flight;
  logic                push;
  logic                pop;
  result_t             push_data;
  result_t             head;

  assign push      = s2_v_r;
  assign pop       = out_valid && out_ready;
  assign in_flight = fifo_cnt_r + CNT_W'(s1_v_r) + CNT_W'(s2_v_r);
  assign in_ready  = !clr_busy_r && (in_flight < CNT_W'(FIFO_DEPTH));

  assign push_data.bin_value = s2_rd_r ? s2_rd_val : '0;
  assign push_data.status    = s2_stat_r;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign head             = fifo_mem[rd_ptr_r];
  assign out_valid        = fifo_cnt_r != '0;
  assign out_bin_value    = head.bin_value;
  assign out_event_number = head.status.event_number;
  assign out_run_number   = head.status.run_number;
  assign out_parse_phase  = head.status.phase;
  assign out_finished     = head.status.finished;

  // ------------------------------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------------------------------

  // The queue plus the two pipeline stages never hold more than the queue can take.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_flight <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overrun");

  // No request is in the pipeline while the clearing pass owns the memories.
  a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s1_v_r && !s2_v_r && (fifo_cnt_r == '0))
    else $error("request in flight during clearing pass");

  // Once the file end marker is seen, the parser stays finished.
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r && (phase_r == PH_DONE))
    else $error("finished flag dropped");

  // A result leaving stage 2 while nothing is popped raises the queue count in the following cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> fifo_cnt_r == $past(fifo_cnt_r) + CNT_W'(1))
    else $error("result lost");

endmodule
